[hdl/mkslp_pkg.sv]
package mkslp_pkg;

	localparam int NUM_KEYS_DEF = 4;
	localparam int KEY_W        = 3;
	localparam int TIME_W       = 32;
	localparam int THR_W        = 16;
	localparam int DATA_W       = 32;
	localparam int PADDR_W      = 2;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [THR_W-1:0]   LONG_PRESS_RST      = 16'd800;
	localparam logic [PADDR_W-1:0] REG_ADDR_LONG_PRESS = 2'd0;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic KIND_SHORT = 1'b0;
	localparam logic KIND_LONG  = 1'b1;

	// one queued word between front and back
	typedef struct packed {
		logic              is_tick;
		logic [KEY_W-1:0]  key_id;
		logic              pressed;
		logic [TIME_W-1:0] now_ms;
	} mkslp_cmd_t;

endpackage

[hdl/mkslp_if.sv]
interface mkslp_item_if import mkslp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [KEY_W-1:0]  key_id;
	logic              pressed;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, cmd, key_id, pressed, now_ms, input ready);
	modport sink (input valid, cmd, key_id, pressed, now_ms, output ready);
endinterface

interface mkslp_result_if import mkslp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             press_kind;
	logic [KEY_W-1:0] press_key;
	logic             last;

	modport source (output valid, press_kind, press_key, last, input ready);
	modport sink (input valid, press_kind, press_key, last, output ready);
endinterface

[hdl/mkslp_front.sv]
module mkslp_front import mkslp_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	mkslp_item_if.sink item,
	input  logic       q_full,
	output logic       q_push,
	output mkslp_cmd_t q_word
);

	logic key_ok;
	logic is_tick;

	assign is_tick = (item.cmd == CMD_TICK);
	assign key_ok  = (item.key_id != '0) && (32'(item.key_id) <= 32'(NUM_KEYS));

	// take a word whenever the queue has room; drop push words for absent keys
	assign item.ready = !q_full;
	assign q_push     = item.valid && !q_full && (is_tick || key_ok);

	assign q_word.is_tick = is_tick;
	assign q_word.key_id  = item.key_id;
	assign q_word.pressed = item.pressed;
	assign q_word.now_ms  = item.now_ms;

endmodule

[hdl/mkslp_fifo.sv]
module mkslp_fifo import mkslp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mkslp_cmd_t wr_word,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output mkslp_cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mkslp_cmd_t      mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full       = (count_q == (PW+1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/mkslp_back.sv]
module mkslp_back import mkslp_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [THR_W-1:0] long_press_ms,
	input  logic             head_valid,
	input  mkslp_cmd_t       head,
	output logic             pop,
	mkslp_result_if.source   result
);

	localparam int SLOT_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]          state_q;
	logic [NUM_KEYS-1:0] key_down_q;
	logic [NUM_KEYS-1:0] long_done_q;
	logic [TIME_W-1:0]   press_time_q [NUM_KEYS];
	logic [TIME_W-1:0]   now_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [KEY_W-1:0]    pend_key_q;
	logic                have_pend_q;

	logic                out_valid_q;
	logic                out_kind_q;
	logic [KEY_W-1:0]    out_key_q;
	logic                out_last_q;

	logic [KEY_W:0]      key_m1;
	logic [SLOT_W-1:0]   head_slot;
	logic [SLOT_W-1:0]   rd_slot;
	logic [TIME_W-1:0]   rd_now;
	logic [TIME_W-1:0]   elapsed;
	logic                below;
	logic [SLOT_W:0]     idx_p1;
	logic [KEY_W-1:0]    idx_key;
	logic                out_free;
	logic                is_short;
	logic                fire;
	logic                scan_go;
	logic                scan_end;
	logic                out_load;
	logic                out_kind_d;
	logic [KEY_W-1:0]    out_key_d;
	logic                out_last_d;

	assign key_m1    = {1'b0, head.key_id} - 1'b1;
	assign head_slot = SLOT_W'(key_m1);

	// one elapsed-time subtractor, shared by release checks and the tick scan
	assign rd_slot = (state_q == ST_SCAN) ? idx_q : head_slot;
	assign rd_now  = (state_q == ST_SCAN) ? now_q : head.now_ms;
	assign elapsed = rd_now - press_time_q[rd_slot];
	assign below   = elapsed < {{(TIME_W-THR_W){1'b0}}, long_press_ms};

	assign idx_p1  = {1'b0, idx_q} + 1'b1;
	assign idx_key = KEY_W'(idx_p1);

	assign out_free = !out_valid_q || result.ready;
	assign is_short = key_down_q[rd_slot] && !long_done_q[rd_slot] && below;
	assign fire     = key_down_q[rd_slot] && !long_done_q[rd_slot] && !below;
	assign scan_end = (idx_q == SLOT_W'(NUM_KEYS-1));
	// hold the scan while a found long press has nowhere to go
	assign scan_go  = (state_q == ST_SCAN) && !(fire && have_pend_q && !out_free);

	always_comb begin
		pop        = 1'b0;
		out_load   = 1'b0;
		out_kind_d = KIND_LONG;
		out_key_d  = pend_key_q;
		out_last_d = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (head.is_tick || head.pressed) begin
						pop = 1'b1;
					end else if (!is_short || out_free) begin
						pop        = 1'b1;
						out_load   = is_short;
						out_kind_d = KIND_SHORT;
						out_key_d  = head.key_id;
					end
				end
			end
			ST_SCAN: begin
				// a newer find proves the held one is not the last
				out_load   = scan_go && fire && have_pend_q;
				out_last_d = 1'b0;
			end
			ST_FLUSH: begin
				out_load = have_pend_q && out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop && !head.is_tick) begin
			if (head.pressed) begin
				press_time_q[head_slot] <= head.now_ms;
			end
		end
		if (state_q == ST_IDLE && pop && head.is_tick) begin
			now_q <= head.now_ms;
		end
		if (scan_go && fire) begin
			pend_key_q <= idx_key;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_key_q  <= out_key_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_down_q  <= '0;
			long_done_q <= '0;
			idx_q       <= '0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.is_tick) begin
							idx_q       <= '0;
							have_pend_q <= 1'b0;
							state_q     <= ST_SCAN;
						end else if (head.pressed) begin
							key_down_q[head_slot]  <= 1'b1;
							long_done_q[head_slot] <= 1'b0;
						end else begin
							key_down_q[head_slot] <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (fire) begin
							long_done_q[idx_q] <= 1'b1;
							have_pend_q        <= 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!have_pend_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						have_pend_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.press_kind = out_kind_q;
	assign result.press_key  = out_key_q;
	assign result.last       = out_last_q;

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten while full");

	a_no_pop_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue popped while a tick is in progress");

	a_scan_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && pop && head.is_tick) |=> (idx_q == '0 && !have_pend_q))
		else $error("tick scan did not start at the first key");

	a_last_not_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |-> (state_q != ST_SCAN))
		else $error("final word emitted before the scan ended");

endmodule

[hdl/multi_key_short_long_press_core.sv]
// Short/long press detector for keys 1..NUM_KEYS. Each item word is either a push
// event (cmd 0: key_id went down or was released at now_ms) or a tick (cmd 1:
// current time now_ms). A release reports a short press when the key was down, no
// long press fired during the hold, and the elapsed time (modulo 2^32) is below
// long_press_ms; a tick reports a long press, once per hold, for every held key
// whose elapsed time has reached long_press_ms, in ascending key order. The last
// result word of each item carries last = 1; items that cause nothing emit
// nothing. Push events for key 0 or keys above NUM_KEYS are dropped at the front.
// Words pass through a two-entry queue, so the input keeps flowing while the back
// end works. In the back end a push event is handled straight from the queue head;
// a tick is taken from the queue, then scanned one key per cycle through the
// single elapsed-time subtractor, and then its final result is released; any
// step waits only while the result register is held by the sink.
// long_press_ms lives at APB address 0 (reset 800); the user must write it only
// while the block is idle, which the block itself does not enforce.
module multi_key_short_long_press_core import mkslp_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	mkslp_item_if.sink         item,
	mkslp_result_if.source     result
);

	logic [THR_W-1:0] long_press_ms_q;
	logic             q_full;
	logic             q_push;
	mkslp_cmd_t       q_word;
	logic             q_pop;
	logic             q_head_valid;
	mkslp_cmd_t       q_head;

	// single register: every write lands in long_press_ms
	assign pready = 1'b1;
	assign prdata = (paddr == REG_ADDR_LONG_PRESS) ?
		{{(DATA_W-THR_W){1'b0}}, long_press_ms_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms_q <= LONG_PRESS_RST;
		end else if (psel && penable && pwrite) begin
			long_press_ms_q <= pwdata[THR_W-1:0];
		end
	end

	// classify and enqueue incoming words
	mkslp_front #(.NUM_KEYS(NUM_KEYS)) u_front (
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_word (q_word)
	);

	// decouple intake from execution
	mkslp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_word    (q_word),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// hold per-key state, run releases and tick scans, drive results
	mkslp_back #(.NUM_KEYS(NUM_KEYS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.long_press_ms (long_press_ms_q),
		.head_valid    (q_head_valid),
		.head          (q_head),
		.pop           (q_pop),
		.result        (result)
	);

endmodule
